FILE: sv/acm_pkg.sv
`default_nettype none
package acm_pkg;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PADDR_W = 3;

  // apb register index
  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    OP_LDAA     = 4'd0,
    OP_LDAZ     = 4'd1,
    OP_LOAD     = 4'd2,
    OP_ADDZ     = 4'd3,
    OP_ADDA     = 4'd4,
    OP_MULZ     = 4'd5,
    OP_MULA     = 4'd6,
    OP_WRA      = 4'd7,
    OP_JMP      = 4'd8,
    OP_JIZ      = 4'd9,
    OP_JNZ      = 4'd10,
    OP_DISPA    = 4'd11,
    OP_STOP     = 4'd12,
    OP_TESTSTOP = 4'd13
  } op_e;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_LEFT    = 3'd1,
    ST_STOP    = 3'd2,
    ST_TSTOP   = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_OVER    = 3'd5,
    ST_NEG     = 3'd6
  } status_e;

  // request from the execute logic to the data memory
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  // memory answer, read data valid in the cycle after rd_en
  typedef struct packed {
    logic              busy;
    logic              word_valid;
    logic [DATA_W-1:0] word;
  } mem_rsp_t;

endpackage
`default_nettype wire

FILE: sv/acm_in_if.sv
`default_nettype none
interface acm_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic signed [31:0] operand;

  modport source (output valid, operation, operand, input ready);
  modport sink   (input valid, operation, operand, output ready);
endinterface
`default_nettype wire

FILE: sv/acm_out_if.sv
`default_nettype none
interface acm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] next_counter;
  logic signed [31:0] accumulator_value;
  logic               display_valid;

  modport source (output valid, status, next_counter, accumulator_value, display_valid,
                  input ready);
  modport sink   (input valid, status, next_counter, accumulator_value, display_valid,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/accumulator_machine_step.sv
// Accumulator machine that executes one instruction per input beat. An instruction is
// accepted, its data word is read from the synchronous RAM at the accept edge, and it
// then executes and lands in the output register once that register is free or drained;
// the next instruction is taken only after the execute stage has emptied, as the
// registered RAM read must finish before the accumulator is updated. A waiting result
// does not block the next accept. After reset a sweep clears the valid bits of all
// MAX_ADDRESS + 1 words (1001 by default), and no instruction is taken while it runs;
// APB writes to program_length (byte address 0) are taken at any time. Once halted,
// every further instruction returns the stored halt status and changes nothing.
`default_nettype none
module accumulator_machine_step import acm_pkg::*; #(
  parameter int unsigned MAX_ADDRESS = 1000
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  acm_in_if.sink                  in_i,
  acm_out_if.source               out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [LEN_W-1:0] len_q;
  mem_req_t         mem_req;
  mem_rsp_t         mem_rsp;

  // apb register file
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PROGRAM_LENGTH) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? 32'(len_q) : '0;

  acm_exec #(
    .MAX_ADDRESS (MAX_ADDRESS)
  ) u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .len_i     (len_q),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

  acm_mem #(
    .MAX_ADDRESS (MAX_ADDRESS)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

endmodule
`default_nettype wire

FILE: sv/acm_mem.sv
`default_nettype none
module acm_mem import acm_pkg::*; #(
  parameter int unsigned MAX_ADDRESS = 1000
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mem_req_t req_i,
  output mem_rsp_t      rsp_o
);

  localparam int unsigned DEPTH = MAX_ADDRESS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] data_mem  [DEPTH];
  logic              valid_mem [DEPTH];

  logic [DATA_W-1:0] word_q;
  logic              vld_q;
  logic              clr_busy_q;
  logic [AW-1:0]     clr_idx_q;

  // clearing sweep over the valid bits after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == AW'(MAX_ADDRESS)) begin
        clr_busy_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // data words, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      data_mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      word_q <= data_mem[req_i.rd_addr[AW-1:0]];
    end
  end

  // valid bits, cleared by the sweep
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      valid_mem[clr_idx_q] <= 1'b0;
    end else if (req_i.wr_en) begin
      valid_mem[req_i.wr_addr[AW-1:0]] <= 1'b1;
    end
    if (req_i.rd_en) begin
      vld_q <= valid_mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rsp_o.busy       = clr_busy_q;
  assign rsp_o.word_valid = vld_q;
  assign rsp_o.word       = word_q;

endmodule
`default_nettype wire

FILE: sv/acm_exec.sv
`default_nettype none
module acm_exec import acm_pkg::*; #(
  parameter int unsigned MAX_ADDRESS = 1000
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  acm_in_if.sink                in_i,
  acm_out_if.source             out_o,
  input  wire logic [LEN_W-1:0] len_i,
  output mem_req_t              mem_req_o,
  input  wire mem_rsp_t         mem_rsp_i
);

  // architectural state
  logic [DATA_W-1:0] acc_q, pc_q;
  logic              halted_q;
  status_e           reason_q;

  // execute stage
  logic              e_valid_q;
  op_e               e_op_q;
  logic [DATA_W-1:0] e_arg_q;
  logic              e_ok_q;
  logic              e_neg_q;

  // output register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_pc_q, out_acc_q;
  logic              out_disp_q;

  logic              accept, e_fire;
  logic [DATA_W-1:0] raddr;
  logic              raddr_neg, raddr_over;

  logic [DATA_W-1:0] len32, rd_word, opnd_b, sum, prod, acc_d, pc_d;
  status_e           st;
  logic              disp, adv, wr;

  // accept side: address of the read is fixed here
  assign in_i.ready = !e_valid_q && !mem_rsp_i.busy;
  assign accept     = in_i.valid && in_i.ready;
  assign raddr      = (op_e'(in_i.operation) == OP_LOAD) ? acc_q : DATA_W'(in_i.operand);
  assign raddr_neg  = raddr[DATA_W-1];
  assign raddr_over = !raddr_neg && (raddr > DATA_W'(MAX_ADDRESS));

  assign e_fire = e_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (accept) begin
      e_valid_q <= 1'b1;
    end else if (e_fire) begin
      e_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_op_q  <= op_e'(in_i.operation);
      e_arg_q <= DATA_W'(in_i.operand);
      e_ok_q  <= !raddr_neg && !raddr_over;
      e_neg_q <= raddr_neg;
    end
  end

  // execute: read data from memory, update accumulator and counter
  assign len32   = DATA_W'(len_i);
  assign rd_word = (e_ok_q && mem_rsp_i.word_valid) ? mem_rsp_i.word : '0;
  assign opnd_b  = (e_op_q == OP_ADDZ || e_op_q == OP_MULZ) ? e_arg_q : rd_word;
  assign sum     = acc_q + opnd_b;
  assign prod    = acc_q * opnd_b;

  always_comb begin
    acc_d = acc_q;
    pc_d  = pc_q;
    st    = ST_RUN;
    disp  = 1'b0;
    adv   = 1'b1;
    wr    = 1'b0;
    if (halted_q) begin
      st = reason_q;
    end else if (!(pc_q < len32)) begin
      st = ST_LEFT;
    end else begin
      case (e_op_q)
        OP_LDAA, OP_LOAD: acc_d = rd_word;
        OP_LDAZ:          acc_d = e_arg_q;
        OP_ADDZ, OP_ADDA: acc_d = sum;
        OP_MULZ, OP_MULA: acc_d = prod;
        OP_WRA: begin
          if (e_neg_q) begin
            st  = ST_NEG;
            adv = 1'b0;
          end else if (!e_ok_q) begin
            st  = ST_OVER;
            adv = 1'b0;
          end else begin
            wr = 1'b1;
          end
        end
        OP_JMP:      pc_d = e_arg_q;
        OP_JIZ:      if (acc_q == '0) pc_d = e_arg_q;
        OP_JNZ:      if (acc_q != '0) pc_d = e_arg_q;
        OP_DISPA:    disp = 1'b1;
        OP_STOP: begin
          st  = ST_STOP;
          adv = 1'b0;
        end
        OP_TESTSTOP: st = ST_TSTOP;
        default: begin
          st  = ST_UNKNOWN;
          adv = 1'b0;
        end
      endcase
      // counter steps when the instruction left it where it was, except on stop, unknown opcode or a failed write
      if (adv && pc_d == pc_q) begin
        pc_d = pc_q + 1'b1;
      end
      if (st == ST_RUN && !(pc_d < len32)) begin
        st = ST_LEFT;
      end
    end
  end

  // state write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pc_q     <= '0;
      halted_q <= 1'b0;
      reason_q <= ST_RUN;
    end else if (e_fire) begin
      acc_q <= acc_d;
      pc_q  <= pc_d;
      if (st != ST_RUN) begin
        halted_q <= 1'b1;
        reason_q <= st;
      end
    end
  end

  // memory port
  assign mem_req_o.rd_en   = accept;
  assign mem_req_o.rd_addr = raddr[ADDR_W-1:0];
  assign mem_req_o.wr_en   = e_fire && wr;
  assign mem_req_o.wr_addr = e_arg_q[ADDR_W-1:0];
  assign mem_req_o.wr_data = acc_q;

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (e_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      out_status_q <= st;
      out_pc_q     <= pc_d;
      out_acc_q    <= acc_d;
      out_disp_q   <= disp;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = out_status_q;
  assign out_o.next_counter      = out_pc_q;
  assign out_o.accumulator_value = out_acc_q;
  assign out_o.display_valid     = out_disp_q;

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag dropped");

  a_halt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> ($stable(acc_q) && $stable(pc_q)))
    else $error("state changed while halted");

  a_fire_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire |=> !e_valid_q)
    else $error("execute stage not drained after fire");

  a_disp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_disp_q) |-> (out_status_q == ST_RUN || out_status_q == ST_LEFT))
    else $error("display beat with halting status");
`endif

endmodule
`default_nettype wire
